[rtl/core/rcl_pkg.sv]
// Shared types, codes and helpers for the RIFF chunk locator.
`default_nettype none
package rcl_pkg;

	localparam logic [31:0] FOURCC_LIST = 32'h5453_494C;
	localparam logic [31:0] FOURCC_RIFF = 32'h4646_4952;
	localparam logic [3:0]  HEADER_BYTES = 4'd8;
	localparam logic [3:0]  TYPE_BYTES = 4'd4;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_INDEX_W = 2;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TARGET_ID     = 2'd0,
		REG_SEARCH_KIND   = 2'd1,
		REG_REGION_LENGTH = 2'd2
	} cfg_reg_t;

	// Search kinds; the unused code never matches a header.
	typedef enum logic [1:0] {
		SEARCH_CHUNK = 2'd0,
		SEARCH_LIST  = 2'd1,
		SEARCH_RIFF  = 2'd2
	} search_kind_t;

	typedef enum logic {
		ITEM_DATA  = 1'b0,
		ITEM_START = 1'b1
	} item_kind_t;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_HEADER = 4'b0010,
		PH_TYPE   = 4'b0100,
		PH_SKIP   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic        found;
		logic [31:0] chunk_id;
		logic [31:0] chunk_length;
		logic [31:0] list_type;
		logic [32:0] consumed;
	} result_t;

	typedef struct packed {
		logic [31:0] target_id;
		logic [1:0]  search_kind;
		logic [31:0] region_length;
	} cfg_t;

	// Adds a small byte count to a position, saturating at the 33-bit maximum.
	function automatic logic [32:0] sat_add(input logic [32:0] a, input logic [3:0] n);
		logic [33:0] s;
		s = {1'b0, a} + {30'd0, n};
		return s[33] ? '1 : s[32:0];
	endfunction

endpackage
`default_nettype wire

[rtl/core/rcl_in_stage.sv]
// Input register stage: holds one accepted word until the parser takes it.
`default_nettype none
module rcl_in_stage
	import rcl_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_ready,
	input  wire item_t item,
	input  wire logic  advance,
	output logic       valid_s1,
	output item_t      item_s1
);

	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

endmodule
`default_nettype wire

[rtl/core/rcl_parser.sv]
// Header parser: search state and the per-byte update for one word.
`default_nettype none
module rcl_parser
	import rcl_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  step,
	input  wire item_t item_s1,
	input  wire cfg_t  cfg,
	output logic       emit,
	output result_t    result
);

	phase_t      phase_q, phase_d;
	logic [2:0]  idx_q, idx_d;
	logic [63:0] header_q, header_d, hdr_new;
	logic [31:0] type_q, type_d, typ_new;
	logic [32:0] skip_q, skip_d, skip_n;
	logic [32:0] pos_q, pos_d;
	logic [32:0] padded_cur, padded_new;
	logic        do_skip, need_end;

	always_comb begin
		hdr_new = header_q;
		hdr_new[{idx_q, 3'b000} +: 8] = item_s1.data_byte;
		typ_new = type_q;
		typ_new[{idx_q[1:0], 3'b000} +: 8] = item_s1.data_byte;
		padded_cur = {1'b0, header_q[63:32]} + {32'd0, header_q[32]};
		padded_new = {1'b0, hdr_new[63:32]} + {32'd0, hdr_new[32]};
	end

	always_comb begin
		phase_d  = phase_q;
		idx_d    = idx_q;
		header_d = header_q;
		type_d   = type_q;
		skip_d   = skip_q;
		pos_d    = pos_q;
		emit     = 1'b0;
		result   = '0;
		do_skip  = 1'b0;
		skip_n   = '0;
		need_end = 1'b0;

		if (item_s1.kind == ITEM_START) begin
			pos_d    = '0;
			type_d   = '0;
			skip_d   = '0;
			need_end = 1'b1;
		end else begin
			case (phase_q)
				PH_HEADER: begin
					header_d = hdr_new;
					idx_d    = idx_q + 3'd1;
					if (idx_q == 3'd7) begin
						pos_d = sat_add(pos_q, HEADER_BYTES);
						if (cfg.search_kind == SEARCH_CHUNK) begin
							if (hdr_new[31:0] == cfg.target_id) begin
								emit                = 1'b1;
								result.found        = 1'b1;
								result.chunk_id     = hdr_new[31:0];
								result.chunk_length = hdr_new[63:32];
								result.consumed     = pos_d;
								phase_d             = PH_IDLE;
							end else begin
								do_skip = 1'b1;
								skip_n  = padded_new;
							end
						end else if ((cfg.search_kind == SEARCH_LIST &&
								hdr_new[31:0] == FOURCC_LIST) ||
								(cfg.search_kind == SEARCH_RIFF &&
								hdr_new[31:0] == FOURCC_RIFF)) begin
							phase_d = PH_TYPE;
							idx_d   = '0;
							type_d  = '0;
						end else begin
							do_skip = 1'b1;
							skip_n  = padded_new;
						end
					end
				end
				PH_TYPE: begin
					type_d = typ_new;
					idx_d  = idx_q + 3'd1;
					if (idx_q == 3'd3) begin
						pos_d = sat_add(pos_q, TYPE_BYTES);
						if (typ_new == cfg.target_id) begin
							emit                = 1'b1;
							result.found        = 1'b1;
							result.chunk_id     = header_q[31:0];
							result.chunk_length = header_q[63:32];
							result.list_type    = typ_new;
							result.consumed     = pos_d;
							phase_d             = PH_IDLE;
						end else begin
							do_skip = 1'b1;
							// The type bytes already count against the body.
							skip_n  = (padded_cur >= {29'd0, TYPE_BYTES}) ?
								padded_cur - {29'd0, TYPE_BYTES} : '0;
						end
					end
				end
				PH_SKIP: begin
					pos_d  = sat_add(pos_q, 4'd1);
					skip_d = (skip_q != '0) ? skip_q - 33'd1 : '0;
					if (skip_d == '0) begin
						need_end = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end

		if (do_skip) begin
			if (skip_n == '0) begin
				need_end = 1'b1;
			end else begin
				skip_d  = skip_n;
				phase_d = PH_SKIP;
			end
		end

		// Fewer than a full header left in the region ends the search.
		if (need_end) begin
			if (({1'b0, pos_d} + {30'd0, HEADER_BYTES}) > {2'b00, cfg.region_length}) begin
				emit            = 1'b1;
				result.consumed = pos_d;
				phase_d         = PH_IDLE;
			end else begin
				phase_d  = PH_HEADER;
				idx_d    = '0;
				header_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			idx_q    <= '0;
			header_q <= '0;
			type_q   <= '0;
			skip_q   <= '0;
			pos_q    <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			idx_q    <= idx_d;
			header_q <= header_d;
			type_q   <= type_d;
			skip_q   <= skip_d;
			pos_q    <= pos_d;
		end
	end

	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SKIP |-> skip_q != '0)
		else $error("skip phase entered with nothing to skip");

	a_type_index: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_TYPE |-> idx_q < 3'd4)
		else $error("list type byte index out of range");

	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit |=> phase_q == PH_IDLE)
		else $error("search still armed after its result");

	a_start_result: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit && item_s1.kind == ITEM_START |->
			!result.found && result.consumed == '0)
		else $error("start word gave a wrong short-region result");

	a_notfound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !result.found |->
			result.chunk_id == '0 && result.chunk_length == '0 && result.list_type == '0)
		else $error("not-found result carries header fields");

endmodule
`default_nettype wire

[rtl/core/rcl_out_stage.sv]
// Result register: holds one result word until the consumer takes it.
`default_nettype none
module rcl_out_stage
	import rcl_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire result_t result_in,
	output logic         free,
	output logic         result_valid,
	input  wire logic    result_ready,
	output result_t      result
);

	logic    valid_q;
	result_t data_q;

	// The slot can take a new word when empty or when it empties this cycle.
	assign free         = !valid_q || result_ready;
	assign result_valid = valid_q;
	assign result       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result_in;
		end
	end

endmodule
`default_nettype wire

[rtl/core/riff_chunk_locator_top.sv]
// Top level of the RIFF chunk locator: configuration registers and stage wiring.
//
//  Port group    Dir  Handshake                   Word
//  item          in   item_valid / item_ready     item_t: kind, data_byte
//  result        out  result_valid / result_ready result_t: found .. consumed
//  cfg           in   cfg_we (no wait)            cfg_index, cfg_data
//
// One word is accepted per cycle while the input register is empty or the result
// register is free. Each word passes the input register and is then parsed from
// it. If it ends a search, its result is loaded into the result register at the
// edge that ends its parse, and the result is offered from the result register.
// A stalled result register holds the parser and then the input register.
// Reset clears the configuration, the search state and both valid flags.
`default_nettype none
module riff_chunk_locator_top
	import rcl_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   item_valid,
	output logic                        item_ready,
	input  wire item_t                  item,
	output logic                        result_valid,
	input  wire logic                   result_ready,
	output result_t                     result,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t    cfg_q;
	logic    valid_s1;
	item_t   item_s1;
	logic    out_free;
	logic    step;
	logic    emit;
	result_t parsed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET_ID:     cfg_q.target_id <= cfg_data;
				REG_SEARCH_KIND:   cfg_q.search_kind <= cfg_data[1:0];
				REG_REGION_LENGTH: cfg_q.region_length <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign step = valid_s1 && out_free;

	rcl_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.advance    (out_free),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	rcl_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.item_s1 (item_s1),
		.cfg     (cfg_q),
		.emit    (emit),
		.result  (parsed)
	);

	rcl_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (step && emit),
		.result_in    (parsed),
		.free         (out_free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
`default_nettype wire

[tb/sv/tb_riff_chunk_locator_top.sv]
// Self-checking testbench for the RIFF chunk locator: random RIFF streams against a predictor.
`default_nettype none
module tb_riff_chunk_locator_top;
	import rcl_pkg::*;

	localparam logic [1:0]             SEARCH_UNDEFINED = 2'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [32:0]            POS_MAX = '1;
	localparam logic [31:0]            FOURCC_JUNK = 32'h4B4E_554A;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   item_valid = 1'b0;
	logic                   item_ready;
	item_t                  item = '0;
	logic                   result_valid;
	logic                   result_ready = 1'b0;
	result_t                result;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	riff_chunk_locator_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Register copies and search state of the predictor.
	logic [31:0] want_id = '0;
	logic [1:0]  want_kind = '0;
	logic [31:0] region_len = '0;
	phase_t      scan_phase = PH_IDLE;
	logic [3:0]  byte_idx = '0;
	logic [63:0] header_q = '0;
	logic [31:0] type_q = '0;
	logic [32:0] skip_q = '0;
	logic [32:0] pos_q = '0;

	item_t       pending_words[$];
	result_t     expected_finds[$];
	int unsigned queued_words = 0;
	int unsigned accepted_words = 0;
	int unsigned mismatch_count = 0;
	logic        hold_off = 1'b0;
	logic        calm;

	// A stretch of the run in which neither side idles.
	assign calm = (accepted_words >= 600) && (accepted_words < 850);

	function automatic void advance_pos(input logic [3:0] n);
		pos_q = (pos_q > POS_MAX - 33'(n)) ? POS_MAX : pos_q + 33'(n);
	endfunction

	function automatic void post_result(input logic fnd, input logic [31:0] id,
			input logic [31:0] len, input logic [31:0] lt);
		result_t r;
		r.found = fnd;
		r.chunk_id = id;
		r.chunk_length = len;
		r.list_type = lt;
		r.consumed = pos_q;
		expected_finds.push_back(r);
		scan_phase = PH_IDLE;
	endfunction

	// Either the region has no room for another header, or the next one begins.
	function automatic void check_region_end();
		if ({1'b0, pos_q} + 34'd8 > {2'b00, region_len}) begin
			post_result(1'b0, '0, '0, '0);
		end else begin
			scan_phase = PH_HEADER;
			byte_idx = '0;
			header_q = '0;
		end
	endfunction

	function automatic void start_skip(input logic [32:0] n);
		if (n == 0) begin
			check_region_end();
		end else begin
			skip_q = n;
			scan_phase = PH_SKIP;
		end
	endfunction

	function automatic void locate_step(input item_t w);
		logic [31:0] id;
		logic [31:0] len;
		logic [32:0] padded;
		if (w.kind == ITEM_START) begin
			pos_q = '0;
			type_q = '0;
			skip_q = '0;
			check_region_end();
			return;
		end
		case (scan_phase)
			PH_HEADER: begin
				header_q |= 64'(w.data_byte) << (8 * byte_idx[2:0]);
				byte_idx = byte_idx + 4'd1;
				if (byte_idx < HEADER_BYTES)
					return;
				advance_pos(HEADER_BYTES);
				id = header_q[31:0];
				len = header_q[63:32];
				padded = {1'b0, len} + 33'(len[0]);
				if (want_kind == SEARCH_CHUNK) begin
					if (id == want_id)
						post_result(1'b1, id, len, '0);
					else
						start_skip(padded);
				end else if ((want_kind == SEARCH_LIST && id == FOURCC_LIST) ||
						(want_kind == SEARCH_RIFF && id == FOURCC_RIFF)) begin
					scan_phase = PH_TYPE;
					byte_idx = '0;
					type_q = '0;
				end else begin
					start_skip(padded);
				end
			end
			PH_TYPE: begin
				type_q |= 32'(w.data_byte) << (8 * byte_idx[1:0]);
				byte_idx = byte_idx + 4'd1;
				if (byte_idx < TYPE_BYTES)
					return;
				advance_pos(TYPE_BYTES);
				id = header_q[31:0];
				len = header_q[63:32];
				padded = {1'b0, len} + 33'(len[0]);
				// A list whose type differs is skipped past its body less the type.
				if (type_q == want_id)
					post_result(1'b1, id, len, type_q);
				else
					start_skip((padded >= 33'(TYPE_BYTES)) ? padded - 33'(TYPE_BYTES) : '0);
			end
			PH_SKIP: begin
				advance_pos(4'd1);
				if (skip_q != 0)
					skip_q = skip_q - 33'd1;
				if (skip_q == 0)
					check_region_end();
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				locate_step(item);
				accepted_words <= accepted_words + 1;
			end
			if (!item_valid || item_ready) begin
				if (pending_words.size() != 0 &&
						(calm || hold_off || $urandom_range(99) >= 34)) begin
					item <= pending_words.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_finds.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result: found %0d id %h length %h type %h consumed %h",
							result.found, result.chunk_id, result.chunk_length,
							result.list_type, result.consumed);
				end else begin
					want = expected_finds.pop_front();
					if (result.found !== want.found || result.chunk_id !== want.chunk_id ||
							result.chunk_length !== want.chunk_length ||
							result.list_type !== want.list_type ||
							result.consumed !== want.consumed) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("bad result (expected/got): found %0d/%0d id %h/%h length %h/%h type %h/%h consumed %h/%h",
								want.found, result.found, want.chunk_id, result.chunk_id,
								want.chunk_length, result.chunk_length, want.list_type,
								result.list_type, want.consumed, result.consumed);
					end
				end
			end
			result_ready <= !hold_off && (calm || $urandom_range(99) >= 34);
		end
	end

	// The receiver holds off for a long stretch while the sender keeps offering words.
	initial begin
		do @(negedge clk); while (accepted_words < 300 || pending_words.size() < 40);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (120) @(posedge clk);
		hold_off <= 1'b0;
	end

	task automatic queue_word(input logic [7:0] b);
		pending_words.push_back('{ITEM_DATA, b});
		queued_words++;
	endtask

	task automatic queue_start();
		pending_words.push_back('{ITEM_START, 8'($urandom())});
		queued_words++;
	endtask

	task automatic queue_fourcc(input logic [31:0] v);
		for (int k = 0; k < 4; k++)
			queue_word(v[8*k +: 8]);
	endtask

	function automatic logic [31:0] any_fourcc();
		case ($urandom_range(5))
			0: return FOURCC_LIST;
			1: return FOURCC_RIFF;
			2: return want_id;
			3: return FOURCC_JUNK;
			default: return $urandom();
		endcase
	endfunction

	// One search: a start, then headers and bodies until a match or the region runs out.
	task automatic queue_search();
		int unsigned budget;
		int unsigned used;
		int unsigned body;
		logic [31:0] id;
		logic [31:0] len;
		bit hit;
		bit done;
		bit typed;
		queue_start();
		if ($urandom_range(11) == 0) begin
			// Broken off part way; the next start abandons it.
			repeat ($urandom_range(20)) queue_word(8'($urandom()));
			return;
		end
		budget = (region_len > 160) ? 160 : region_len;
		used = 0;
		done = (budget < 8);
		while (!done) begin
			hit = (want_kind != SEARCH_UNDEFINED) && ($urandom_range(3) == 0 || used > 100);
			len = $urandom_range(13);
			// A matched header is never skipped, so its length may be anything.
			if (hit && $urandom_range(1) == 1)
				len = $urandom();
			case (want_kind)
				SEARCH_CHUNK: id = hit ? want_id : any_fourcc();
				SEARCH_LIST: id = (hit || $urandom_range(1) == 1) ? FOURCC_LIST : any_fourcc();
				SEARCH_RIFF: id = (hit || $urandom_range(1) == 1) ? FOURCC_RIFF : any_fourcc();
				default: id = any_fourcc();
			endcase
			typed = (want_kind == SEARCH_LIST && id == FOURCC_LIST) ||
				(want_kind == SEARCH_RIFF && id == FOURCC_RIFF);
			queue_fourcc(id);
			queue_fourcc(len);
			used += 8;
			if (typed) begin
				queue_fourcc(hit ? want_id : 32'($urandom()));
				used += 4;
			end
			if (hit) begin
				done = 1'b1;
			end else begin
				body = len + 32'(len[0]);
				if (typed)
					body = (body >= 4) ? body - 4 : 0;
				repeat (body) queue_word(8'($urandom()));
				used += body;
				done = (used + 8 > budget);
			end
		end
		// Stray words after the end of a search are ignored by the block.
		if ($urandom_range(7) == 0)
			repeat ($urandom_range(1, 3)) queue_word(8'($urandom()));
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		case (idx)
			REG_TARGET_ID: want_id = v;
			REG_SEARCH_KIND: want_kind = v[1:0];
			REG_REGION_LENGTH: region_len = v;
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Waits until every word has gone in and every result has come out, then lets
	// words that end no search drain through the pipeline.
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_words.size() != 0 || item_valid || expected_finds.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int unsigned p;
		int unsigned phase_base;
		logic [31:0] region;
		logic [31:0] target;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Registers at reset: a word while idle, then a start on an empty region.
		queue_word(8'hA5);
		queue_start();

		// A list search over the largest region with all-ones fields.
		wait_idle();
		write_reg(REG_TARGET_ID, 32'hFFFF_FFFF);
		write_reg(REG_SEARCH_KIND, {30'h3FFF_FFFF, SEARCH_LIST});
		write_reg(REG_REGION_LENGTH, 32'hFFFF_FFFF);
		end_writes();
		queue_start();
		queue_fourcc(FOURCC_LIST);
		queue_fourcc(32'hFFFF_FFFF);
		queue_fourcc(32'hFFFF_FFFF);

		// Undefined search kind, a restart, and a region with room for one header only.
		wait_idle();
		write_reg(REG_TARGET_ID, 32'h0000_0000);
		write_reg(REG_SEARCH_KIND, {30'h0, SEARCH_UNDEFINED});
		write_reg(REG_REGION_LENGTH, 32'd8);
		write_reg(REG_SPARE, $urandom());
		end_writes();
		queue_start();
		queue_word(8'h00);
		queue_start();
		queue_fourcc(FOURCC_RIFF);
		queue_fourcc(32'h0000_0000);

		for (p = 0; p < 14; p++) begin
			wait_idle();
			case ($urandom_range(4))
				0: target = 32'h0000_0000;
				1: target = 32'hFFFF_FFFF;
				2: target = FOURCC_LIST;
				default: target = $urandom();
			endcase
			case ($urandom_range(9))
				0: region = $urandom_range(7);
				1: region = 32'd8;
				2: region = 32'hFFFF_FFFF;
				3: region = $urandom() | 32'h1000_0000;
				default: region = $urandom_range(9, 90);
			endcase
			write_reg(REG_SEARCH_KIND, {30'($urandom()), 2'(p % 4)});
			write_reg(REG_REGION_LENGTH, region);
			write_reg(REG_TARGET_ID, target);
			if ($urandom_range(3) == 0)
				write_reg(REG_SPARE, $urandom());
			end_writes();
			phase_base = queued_words;
			while (queued_words - phase_base < 45)
				queue_search();
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_finds.size() == 0)
			$display("riff_chunk_locator_top: match");
		else
			$display("riff_chunk_locator_top: mismatch");
		$finish;
	end

	initial begin
		#400000;
		$display("riff_chunk_locator_top: mismatch");
		$finish;
	end

endmodule
`default_nettype wire
